// ===== rtl/tap_pkg.sv =====
// Shared types and constants of the Taylor angle predictor.
// No dependencies; every other file but tap_checker imports this package.
package tap_pkg;

  localparam int DEF_MAX_ORDER = 4;

  localparam int TERM_W = 48;   // derivative terms, signed Q16.32
  localparam int MOM_W  = 40;   // moments, unsigned Q32.8 us
  localparam int DIFF_W = 49;   // difference of two terms
  localparam int MD_M_W = 28;   // multiplier operand of the muldiv unit
  localparam int PROD_W = DIFF_W + MD_M_W;

  localparam logic [MD_M_W-1:0] TIME_SCALE = MD_M_W'(256000000);
  localparam logic [MOM_W-1:0]  US_PER_S   = MOM_W'(1000000);
  localparam logic signed [DIFF_W-1:0] PI_Q32     = DIFF_W'(64'sd13493037705);
  localparam logic signed [DIFF_W-1:0] TWO_PI_Q32 = DIFF_W'(64'sd26986075409);

  localparam logic [2:0]  RST_ORDER      = 3'd3;
  localparam logic [15:0] RST_CONFIDENCE = 16'd52429;
  localparam logic [15:0] RST_MIN_IV     = 16'd100;
  localparam logic [29:0] RST_JUMP_LIMIT = 30'd168662974;

  typedef enum logic [1:0] {
    CFG_ORDER      = 2'd0,
    CFG_CONFIDENCE = 2'd1,
    CFG_MIN_IV     = 2'd2,
    CFG_JUMP_LIMIT = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_TOO_SOON = 2'd1,
    ST_JUMP     = 2'd2,
    ST_QUERY    = 2'd3
  } res_status_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_L0, OP_EST, OP_WMUL, OP_BL1, OP_BL2, OP_BL3,
    OP_COPY, OP_PINIT, OP_TLOAD, OP_TSTEP, OP_TSAVE, OP_TSUM, OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic md_done;
    logic action;
    logic too_soon;
    logic jumped;
  } dp_sts_t;

endpackage

// ===== rtl/tap_muldiv.sv =====
// Sequential |a|*m/d unit: shift-add multiply, then restoring divide.
// Truncates toward zero, saturates to the term range. Uses tap_pkg.
module tap_muldiv import tap_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DIFF_W-1:0] a,
  input  logic [MD_M_W-1:0]        m,
  input  logic [MOM_W-1:0]         d,
  input  logic                     flip,
  output logic                     done,
  output logic signed [TERM_W-1:0] q
);

  localparam int CW = $clog2(PROD_W);

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_t;

  md_state_t           state_r;
  logic [PROD_W-1:0]   mc_r, acc_r, quo_r;
  logic [MD_M_W-1:0]   m_r;
  logic [MOM_W-1:0]    d_r;
  logic [MOM_W:0]      rem_r;
  logic [CW-1:0]       cnt_r;
  logic                neg_r, zero_r, dz_r, done_r;
  logic signed [TERM_W-1:0] q_r;

  logic [DIFF_W-1:0]   ua;
  logic [MOM_W:0]      rem_sh, rem_nxt;
  logic                qb;
  logic [PROD_W-1:0]   quo_nxt;
  logic signed [TERM_W-1:0] res, sat_v;

  assign ua = a[DIFF_W-1] ? DIFF_W'(-a) : DIFF_W'(a);

  always_comb begin
    rem_sh  = {rem_r[MOM_W-1:0], acc_r[PROD_W-1]};
    qb      = (rem_sh >= {1'b0, d_r});
    rem_nxt = qb ? rem_sh - {1'b0, d_r} : rem_sh;
    quo_nxt = {quo_r[PROD_W-2:0], qb};
    sat_v   = neg_r ? {1'b1, {(TERM_W-1){1'b0}}} : {1'b0, {(TERM_W-1){1'b1}}};
    if (zero_r)
      res = '0;
    else if (dz_r || (|quo_nxt[PROD_W-1:TERM_W-1]))
      res = sat_v;
    else if (neg_r)
      res = -$signed(quo_nxt[TERM_W-1:0]);
    else
      res = $signed(quo_nxt[TERM_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      // pulse after the last divide step
      done_r <= (state_r == MD_DIV) && (cnt_r == CW'(PROD_W - 1));
      unique case (state_r)
        MD_IDLE: begin
          if (start) begin
            mc_r    <= PROD_W'(ua);
            m_r     <= m;
            acc_r   <= '0;
            d_r     <= d;
            neg_r   <= a[DIFF_W-1] ^ flip;
            zero_r  <= (a == '0) || (m == '0);
            dz_r    <= (d == '0);
            cnt_r   <= '0;
            state_r <= MD_MUL;
          end
        end
        MD_MUL: begin
          if (m_r[0]) acc_r <= acc_r + mc_r;
          mc_r  <= {mc_r[PROD_W-2:0], 1'b0};
          m_r   <= {1'b0, m_r[MD_M_W-1:1]};
          if (cnt_r == CW'(MD_M_W - 1)) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            quo_r   <= '0;
            state_r <= MD_DIV;
          end else
            cnt_r <= cnt_r + 1'b1;
        end
        MD_DIV: begin
          rem_r <= rem_nxt;
          acc_r <= {acc_r[PROD_W-2:0], 1'b0};
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(PROD_W - 1)) begin
            q_r     <= res;
            state_r <= MD_IDLE;
          end
        end
        default: state_r <= MD_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ===== rtl/tap_dp.sv =====
// Datapath: derivative chain storage, blend, Taylor sums, result register.
// Uses tap_pkg and tap_muldiv; driven by tap_ctrl commands.
module tap_dp import tap_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
  localparam int LW = $clog2(MAX_ORDER + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_op_t               op,
  input  logic [LW-1:0]        lvl,
  input  logic [LW-1:0]        kstep,
  input  logic [LW-1:0]        ord,
  input  logic                 in_action,
  input  logic signed [30:0]   in_angle,
  input  logic [31:0]          in_timestamp,
  input  logic [19:0]          in_horizon,
  input  logic [15:0]          confidence,
  input  logic [15:0]          min_interval,
  input  logic [29:0]          jump_limit,
  output dp_sts_t              sts,
  output logic [MAX_ORDER-1:0] cur_known,
  output logic [MAX_ORDER-1:0] prev_known,
  output logic signed [31:0]   res_angle,
  output logic signed [31:0]   res_rate,
  output logic [1:0]           res_status
);

  localparam int SW = TERM_W + IW + 1;
  localparam int PW = TERM_W + 18;

  logic signed [TERM_W-1:0] cur_t_r  [MAX_ORDER];
  logic signed [TERM_W-1:0] prev_t_r [MAX_ORDER];
  logic [MOM_W-1:0]         cur_m_r  [MAX_ORDER];
  logic [MOM_W-1:0]         prev_m_r [MAX_ORDER];
  logic [MAX_ORDER-1:0]     cur_k_r, prev_k_r;

  logic signed [30:0]       ang_r;
  logic [31:0]              ts_r;
  logic [19:0]              h_r;
  logic                     action_r, soon_r, jump_r;
  res_status_t              status_r;
  logic signed [DIFF_W-1:0] chg_r;
  logic [15:0]              w_r;
  logic signed [PW-1:0]     p1_r, p2_r;
  logic signed [TERM_W-1:0] t_r;
  logic signed [SW-1:0]     sum_r, rate_r;
  logic signed [31:0]       out_ang_r, out_rate_r;
  res_status_t              out_st_r;

  logic [LW-1:0]            lvl_m1;
  logic [IW-1:0]            idx, idxm;
  logic signed [TERM_W-1:0] ang_t;
  logic [MOM_W-1:0]         ts_m, dt0, mag_dt0, dt, mag_dt, mid;
  logic signed [DIFF_W-1:0] chg_raw, chg_w1, chg_w, diff_hi, est_diff;
  logic [DIFF_W-1:0]        mag_chg;
  logic                     too_soon, jumped;
  logic [16:0]              w_c;
  logic signed [PW-1:0]     bl_sum;
  logic [31:0]              w_prod;
  logic signed [SW-1:0]     ang_sh, rate_sh;
  logic                     ang_ovf, rate_ovf;

  logic                     md_start, md_flip, md_done;
  logic signed [DIFF_W-1:0] md_a;
  logic [MD_M_W-1:0]        md_m;
  logic [MOM_W-1:0]         md_d;
  logic signed [TERM_W-1:0] md_q;

  always_comb begin
    lvl_m1  = lvl - LW'(1);
    idx     = lvl[IW-1:0];
    idxm    = lvl_m1[IW-1:0];
    ang_t   = {{(TERM_W-35){ang_r[30]}}, ang_r, 4'b0};
    ts_m    = {ts_r, 8'b0};
    dt0     = ts_m - prev_m_r[0];
    mag_dt0 = dt0[MOM_W-1] ? -dt0 : dt0;
    chg_raw = {ang_t[TERM_W-1], ang_t} - {prev_t_r[0][TERM_W-1], prev_t_r[0]};
    chg_w1  = (chg_raw >= PI_Q32) ? chg_raw - TWO_PI_Q32 : chg_raw;
    chg_w   = (chg_w1 <= -PI_Q32) ? chg_w1 + TWO_PI_Q32 : chg_w1;
    mag_chg = chg_w[DIFF_W-1] ? DIFF_W'(-chg_w) : DIFF_W'(chg_w);
    too_soon = prev_k_r[0] && (mag_dt0 < {16'b0, min_interval, 8'b0});
    jumped   = prev_k_r[0] && !too_soon &&
               (mag_chg > {{(DIFF_W-34){1'b0}}, jump_limit, 4'b0});
    // level step: time between the previous level's moments
    dt      = cur_m_r[idxm] - prev_m_r[idxm];
    mag_dt  = dt[MOM_W-1] ? -dt : dt;
    mid     = prev_m_r[idxm] + {dt[MOM_W-1], dt[MOM_W-1:1]};
    diff_hi = {cur_t_r[idxm][TERM_W-1], cur_t_r[idxm]} -
              {prev_t_r[idxm][TERM_W-1], prev_t_r[idxm]};
    est_diff = (lvl == LW'(1)) ? chg_r : diff_hi;
    w_c     = 17'h10000 - {1'b0, w_r};
    bl_sum  = p1_r + p2_r;
    w_prod  = {16'b0, w_r} * {16'b0, confidence};
    ang_sh  = sum_r >>> 4;
    rate_sh = rate_r >>> 8;
    ang_ovf  = !((&ang_sh[SW-1:31]) || !(|ang_sh[SW-1:31]));
    rate_ovf = !((&rate_sh[SW-1:31]) || !(|rate_sh[SW-1:31]));
  end

  always_comb begin
    md_start = 1'b0;
    md_a     = est_diff;
    md_m     = TIME_SCALE;
    md_d     = mag_dt;
    md_flip  = dt[MOM_W-1];
    case (op)
      OP_EST:   md_start = 1'b1;
      OP_TSTEP: begin
        md_start = 1'b1;
        md_a     = {t_r[TERM_W-1], t_r};
        md_m     = {{(MD_M_W-20){1'b0}}, h_r};
        md_d     = MOM_W'(MOM_W'(kstep) * US_PER_S);
        md_flip  = 1'b0;
      end
      default: ;
    endcase
  end

  tap_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a     (md_a),
    .m     (md_m),
    .d     (md_d),
    .flip  (md_flip),
    .done  (md_done),
    .q     (md_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_k_r  <= '0;
      prev_k_r <= '0;
      for (int e = 0; e < MAX_ORDER; e++) begin
        cur_t_r[e]  <= '0;
        prev_t_r[e] <= '0;
        cur_m_r[e]  <= '0;
        prev_m_r[e] <= '0;
      end
    end else begin
      case (op)
        OP_LATCH: begin
          ang_r    <= in_angle;
          ts_r     <= in_timestamp;
          h_r      <= in_horizon;
          action_r <= in_action;
          status_r <= in_action ? ST_QUERY : ST_ACCEPTED;
        end
        OP_L0: begin
          cur_t_r[0] <= ang_t;
          cur_m_r[0] <= ts_m;
          cur_k_r[0] <= 1'b1;
          chg_r      <= prev_k_r[0] ? chg_w : '0;
          soon_r     <= too_soon;
          jump_r     <= jumped;
          status_r   <= too_soon ? ST_TOO_SOON : (jumped ? ST_JUMP : ST_ACCEPTED);
        end
        OP_EST: begin
          cur_m_r[idx] <= mid;
          cur_k_r[idx] <= 1'b1;
          w_r          <= confidence;
        end
        OP_WMUL: w_r  <= w_prod[31:16];
        OP_BL1:  p1_r <= md_q * $signed({1'b0, w_r});
        OP_BL2:  p2_r <= prev_t_r[idx] * $signed({1'b0, w_c});
        OP_BL3:  cur_t_r[idx] <= prev_k_r[idx] ? bl_sum[TERM_W+15:16] : md_q;
        OP_COPY: begin
          for (int e = 0; e < MAX_ORDER; e++) begin
            if (e < int'(ord)) begin
              prev_t_r[e] <= cur_t_r[e];
              prev_m_r[e] <= cur_m_r[e];
              prev_k_r[e] <= cur_k_r[e];
            end
          end
        end
        OP_PINIT: begin
          sum_r  <= {{(SW-TERM_W){cur_t_r[0][TERM_W-1]}}, cur_t_r[0]};
          rate_r <= '0;
        end
        OP_TLOAD: t_r <= cur_t_r[idx];
        OP_TSTEP: begin
          // the rate sum takes the chain one step short of the angle sum
          if (kstep == lvl) rate_r <= rate_r + {{(SW-TERM_W){t_r[TERM_W-1]}}, t_r};
        end
        OP_TSAVE: t_r   <= md_q;
        OP_TSUM:  sum_r <= sum_r + {{(SW-TERM_W){t_r[TERM_W-1]}}, t_r};
        OP_OUT: begin
          out_ang_r  <= ang_ovf ? (ang_sh[SW-1] ? 32'sh80000000 : 32'sh7fffffff)
                                : ang_sh[31:0];
          out_rate_r <= rate_ovf ? (rate_sh[SW-1] ? 32'sh80000000 : 32'sh7fffffff)
                                 : rate_sh[31:0];
          out_st_r   <= status_r;
        end
        default: ;
      endcase
    end
  end

  assign sts.md_done  = md_done;
  assign sts.action   = action_r;
  assign sts.too_soon = soon_r;
  assign sts.jumped   = jump_r;
  assign cur_known    = cur_k_r;
  assign prev_known   = prev_k_r;
  assign res_angle    = out_ang_r;
  assign res_rate     = out_rate_r;
  assign res_status   = out_st_r;

endmodule

// ===== rtl/tap_ctrl.sv =====
// Sequencer: walks the sample update and the Taylor sums level by level.
// Uses tap_pkg; issues dp_op_t commands to tap_dp.
module tap_ctrl import tap_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
  localparam int LW = $clog2(MAX_ORDER + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  input  logic [2:0]           cfg_order,
  input  dp_sts_t              sts,
  input  logic [MAX_ORDER-1:0] cur_known,
  input  logic [MAX_ORDER-1:0] prev_known,
  output dp_op_t               op,
  output logic [LW-1:0]        lvl,
  output logic [LW-1:0]        kstep,
  output logic [LW-1:0]        ord
);

  typedef enum logic [3:0] {
    S_IDLE, S_L0, S_CHK, S_LVL, S_EWAIT, S_WMUL, S_BL1, S_BL2, S_BL3,
    S_COPY, S_PINIT, S_PLVL, S_PSTEP, S_PWAIT, S_PSUM, S_OUT
  } state_t;

  state_t        state_r;
  logic [LW-1:0] lvl_r, k_r, lvl_m1;
  logic          est_go, tay_go, out_go;

  always_comb begin
    if (cfg_order == 3'd0)
      ord = LW'(1);
    else if (int'(cfg_order) > MAX_ORDER)
      ord = LW'(MAX_ORDER);
    else
      ord = LW'(cfg_order);
    lvl_m1 = lvl_r - LW'(1);
    est_go = (lvl_r < ord) && prev_known[lvl_m1[IW-1:0]];
    tay_go = (lvl_r < ord) && cur_known[lvl_r[IW-1:0]];
    out_go = !out_tvalid || out_tready;
  end

  always_comb begin
    op = OP_NONE;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) op = OP_LATCH;
      S_L0:    if (!sts.action) op = OP_L0;
      S_LVL:   if (est_go) op = OP_EST;
      S_WMUL:  op = OP_WMUL;
      S_BL1:   op = OP_BL1;
      S_BL2:   op = OP_BL2;
      S_BL3:   op = OP_BL3;
      S_COPY:  op = OP_COPY;
      S_PINIT: op = OP_PINIT;
      S_PLVL:  if (tay_go) op = OP_TLOAD;
      S_PSTEP: op = OP_TSTEP;
      S_PWAIT: if (sts.md_done) op = OP_TSAVE;
      S_PSUM:  op = OP_TSUM;
      S_OUT:   if (out_go) op = OP_OUT;
      default: op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      lvl_r      <= '0;
      k_r        <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if ((state_r == S_OUT) && out_go)
        out_tvalid <= 1'b1;
      else if (out_tready)
        out_tvalid <= 1'b0;
      unique case (state_r)
        S_IDLE:  if (in_tvalid) state_r <= S_L0;
        S_L0:    state_r <= sts.action ? S_PINIT : S_CHK;
        S_CHK: begin
          if (sts.too_soon)
            state_r <= S_PINIT;
          else if (sts.jumped)
            state_r <= S_COPY;
          else begin
            lvl_r   <= LW'(1);
            state_r <= S_LVL;
          end
        end
        S_LVL: begin
          if (est_go) begin
            k_r     <= LW'(1);
            state_r <= S_EWAIT;
          end else
            state_r <= S_COPY;
        end
        S_EWAIT: if (sts.md_done) state_r <= (k_r < lvl_r) ? S_WMUL : S_BL1;
        S_WMUL: begin
          k_r     <= k_r + LW'(1);
          state_r <= ((k_r + LW'(1)) < lvl_r) ? S_WMUL : S_BL1;
        end
        S_BL1: state_r <= S_BL2;
        S_BL2: state_r <= S_BL3;
        S_BL3: begin
          lvl_r   <= lvl_r + LW'(1);
          state_r <= S_LVL;
        end
        S_COPY: state_r <= S_PINIT;
        S_PINIT: begin
          lvl_r   <= LW'(1);
          state_r <= S_PLVL;
        end
        S_PLVL: begin
          if (tay_go) begin
            k_r     <= LW'(1);
            state_r <= S_PSTEP;
          end else
            state_r <= S_OUT;
        end
        S_PSTEP: state_r <= S_PWAIT;
        S_PWAIT: begin
          if (sts.md_done) begin
            if (k_r == lvl_r)
              state_r <= S_PSUM;
            else begin
              k_r     <= k_r + LW'(1);
              state_r <= S_PSTEP;
            end
          end
        end
        S_PSUM: begin
          lvl_r   <= lvl_r + LW'(1);
          state_r <= S_PLVL;
        end
        S_OUT: begin
          if (out_go)
            state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign lvl       = lvl_r;
  assign kstep     = k_r;

endmodule

// ===== rtl/taylor_angle_predictor.sv =====
// Top level of the Taylor angle predictor: ports, configuration registers.
// Depends on tap_pkg, tap_ctrl, tap_dp (which holds tap_muldiv).
//
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | tdata: angle, timestamp, horizon; tuser: action
// out_    | out | out_tvalid/tready  | tdata: predicted_angle, predicted_rate; tuser: status
// cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_wdata
//
// Flow: one request at a time. Each muldiv runs 28 multiply steps, then 77
//   divide steps; a sample with L = levels uses L-1 of them plus the blend and
//   weight steps, the prediction L(L-1)/2. Both share the one muldiv unit.
// Reset: synchronous, clears the chain's known bits and terms; no clearing pass.
// Stalls: a waiting result is held; the next request is taken meanwhile and
//   its result waits until the first is taken. cfg_ready is always high.
module taylor_angle_predictor import tap_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // angle[30:0], timestamp[62:31], horizon[82:63], zero pad
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // predicted_angle[31:0], predicted_rate[63:32]
  output logic [1:0]  out_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int LW = $clog2(MAX_ORDER + 1);

  logic [2:0]  order_r;
  logic [15:0] conf_r, min_iv_r;
  logic [29:0] jlim_r;

  dp_op_t               op;
  dp_sts_t              sts;
  logic [LW-1:0]        lvl, kstep, ord;
  logic [MAX_ORDER-1:0] cur_known, prev_known;
  logic signed [31:0]   res_angle, res_rate;
  logic [1:0]           res_status;

  assign cfg_ready = 1'b1;

  // configuration is only to be written by the user while no request is in flight; the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r  <= RST_ORDER;
      conf_r   <= RST_CONFIDENCE;
      min_iv_r <= RST_MIN_IV;
      jlim_r   <= RST_JUMP_LIMIT;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ORDER:      order_r  <= cfg_wdata[2:0];
        CFG_CONFIDENCE: conf_r   <= cfg_wdata[15:0];
        CFG_MIN_IV:     min_iv_r <= cfg_wdata[15:0];
        CFG_JUMP_LIMIT: jlim_r   <= cfg_wdata[29:0];
        default: ;
      endcase
    end
  end

  tap_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cfg_order  (order_r),
    .sts        (sts),
    .cur_known  (cur_known),
    .prev_known (prev_known),
    .op         (op),
    .lvl        (lvl),
    .kstep      (kstep),
    .ord        (ord)
  );

  tap_dp #(.MAX_ORDER(MAX_ORDER)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (op),
    .lvl          (lvl),
    .kstep        (kstep),
    .ord          (ord),
    .in_action    (in_tuser),
    .in_angle     ($signed(in_tdata[30:0])),
    .in_timestamp (in_tdata[62:31]),
    .in_horizon   (in_tdata[82:63]),
    .confidence   (conf_r),
    .min_interval (min_iv_r),
    .jump_limit   (jlim_r),
    .sts          (sts),
    .cur_known    (cur_known),
    .prev_known   (prev_known),
    .res_angle    (res_angle),
    .res_rate     (res_rate),
    .res_status   (res_status)
  );

  assign out_tdata = {res_rate, res_angle};
  assign out_tuser = res_status;

endmodule

// ===== rtl/tap_checker.sv =====
// Port-level checks on the Taylor angle predictor, bound to the top level.
// Depends on taylor_angle_predictor's port list only.
module tap_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable({out_tdata, out_tuser}))
    else $error("result changed while stalled");

  // one request at a time: accepting closes the input side
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  // reset leaves no result pending and the input open
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset state wrong");

endmodule

bind taylor_angle_predictor tap_checker u_tap_checker (.*);

// ===== test/taylor_angle_predictor_chk.sv =====
`timescale 1ns / 100ps
// Checker of the Taylor angle predictor: watches the three channels, predicts
// each result and compares it. Depends on tap_pkg.
module taylor_angle_predictor_chk import tap_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [87:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          outstanding
);

  localparam int          LV       = DEF_MAX_ORDER;
  localparam longint      TERM_TOP = 64'sd140737488355327;
  localparam longint      TERM_BOT = -64'sd140737488355328;
  localparam longint      PI_C     = 64'sd13493037705;
  localparam longint      TWO_PI_C = 64'sd26986075409;

  typedef struct {
    logic signed [31:0] ang;
    logic signed [31:0] rate;
    res_status_t        status;
  } pred_t;

  logic [2:0]  r_order;
  logic [15:0] r_conf, r_min_iv;
  logic [29:0] r_jump;

  longint      cur_t [LV], prv_t [LV];
  logic [39:0] cur_m [LV], prv_m [LV];
  bit          cur_k [LV], prv_k [LV];

  pred_t       pending_preds [$];

  // |a| * m / d, truncated, signed, clamped to the 48-bit term range
  function automatic longint scale_sat(longint a, logic [63:0] m, logic [63:0] d, bit flip);
    bit           neg;
    logic [63:0]  ua;
    logic [127:0] p, q;
    neg = (a < 0) != flip;
    ua  = (a < 0) ? 64'(-a) : 64'(a);
    if (ua == 0 || m == 0) return 0;
    if (d == 0) return neg ? TERM_BOT : TERM_TOP;
    p = {64'd0, ua} * {64'd0, m};
    q = p / {64'd0, d};
    if (q >= 128'd140737488355328) return neg ? TERM_BOT : TERM_TOP;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint mom_diff(logic [39:0] a, logic [39:0] b);
    logic [39:0] x;
    longint      r;
    x = a - b;
    r = $signed(x);
    return r;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint horizon_term(longint t, int n, logic [19:0] h);
    for (int k = 1; k <= n; k++) t = scale_sat(t, 64'(h), 64'(1000000 * k), 1'b0);
    return t;
  endfunction

  function automatic void absorb_sample(longint ang, logic [31:0] ts, int lv,
                                        inout res_status_t st);
    longint chg, dt, df, est, w;
    bit     jumped;
    chg = 0;
    jumped = 0;
    cur_t[0] = ang * 16;
    cur_m[0] = {ts, 8'd0};
    cur_k[0] = 1;
    if (prv_k[0]) begin
      dt = mom_diff(cur_m[0], prv_m[0]);
      if (mag(dt) < (longint'(r_min_iv) << 8)) begin
        st = ST_TOO_SOON;
        return;
      end
      chg = cur_t[0] - prv_t[0];
      if (chg >= PI_C) chg -= TWO_PI_C;
      if (chg <= -PI_C) chg += TWO_PI_C;
      if (mag(chg) > (longint'(r_jump) << 4)) begin
        st = ST_JUMP;
        jumped = 1;
      end
    end
    for (int i = 1; !jumped && i < lv; i++) begin
      if (!prv_k[i-1]) break;
      dt = mom_diff(cur_m[i-1], prv_m[i-1]);
      cur_m[i] = prv_m[i-1] + 40'(dt >>> 1);
      cur_k[i] = 1;
      df  = (i == 1) ? chg : cur_t[i-1] - prv_t[i-1];
      est = scale_sat(df, 64'd256000000, 64'(mag(dt)), dt < 0);
      w = r_conf;
      for (int k = 1; k < i; k++) w = (w * r_conf) >> 16;
      if (prv_k[i]) cur_t[i] = (w * est + (65536 - w) * prv_t[i]) >>> 16;
      else          cur_t[i] = est;
    end
    for (int i = 0; i < lv; i++) begin
      prv_t[i] = cur_t[i];
      prv_m[i] = cur_m[i];
      prv_k[i] = cur_k[i];
    end
  endfunction

  function automatic pred_t predict_request(bit act, logic [30:0] ang_f,
                                            logic [31:0] ts, logic [19:0] h);
    pred_t  r;
    int     lv;
    longint sum, rt;
    lv = (r_order == 0) ? 1 : (r_order > LV ? LV : int'(r_order));
    r.status = ST_QUERY;
    if (!act) begin
      r.status = ST_ACCEPTED;
      absorb_sample(longint'($signed(ang_f)), ts, lv, r.status);
    end
    sum = cur_t[0];
    for (int i = 1; i < lv; i++) begin
      if (!cur_k[i]) break;
      sum += horizon_term(cur_t[i], i, h);
    end
    r.rate = 0;
    if (lv > 1 && cur_k[1]) begin
      rt = cur_t[1];
      for (int i = 1; i + 1 < lv; i++) begin
        if (!cur_k[i+1]) break;
        rt += horizon_term(cur_t[i+1], i, h);
      end
      r.rate = clamp32(rt >>> 8);
    end
    r.ang = clamp32(sum >>> 4);
    return r;
  endfunction

  always @(posedge clk) begin
    pred_t exp_r;
    if (!rst_n) begin
      r_order = RST_ORDER;
      r_conf = RST_CONFIDENCE;
      r_min_iv = RST_MIN_IV;
      r_jump = RST_JUMP_LIMIT;
      for (int i = 0; i < LV; i++) begin
        cur_t[i] = 0; prv_t[i] = 0; cur_m[i] = 0; prv_m[i] = 0;
        cur_k[i] = 0; prv_k[i] = 0;
      end
      pending_preds.delete();
      outstanding <= 0;
      fail_count  <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ORDER:      r_order = cfg_wdata[2:0];
          CFG_CONFIDENCE: r_conf = cfg_wdata[15:0];
          CFG_MIN_IV:     r_min_iv = cfg_wdata[15:0];
          CFG_JUMP_LIMIT: r_jump = cfg_wdata[29:0];
        endcase
      end
      if (in_tvalid && in_tready)
        pending_preds.push_back(predict_request(in_tuser, in_tdata[30:0], in_tdata[62:31],
                                                in_tdata[82:63]));
      if (out_tvalid && out_tready) begin
        if (pending_preds.size() == 0) begin
          $display("%0t: unexpected result angle=%0d rate=%0d status=%0d", $time,
                   $signed(out_tdata[31:0]), $signed(out_tdata[63:32]), out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = pending_preds.pop_front();
          if (out_tdata[31:0] !== exp_r.ang || out_tdata[63:32] !== exp_r.rate ||
              out_tuser !== exp_r.status) begin
            $display("%0t: mismatch angle exp %0d got %0d, rate exp %0d got %0d,",
                     $time, exp_r.ang, $signed(out_tdata[31:0]), exp_r.rate,
                     $signed(out_tdata[63:32]));
            $display("%0t:   status exp %0d got %0d", $time, exp_r.status, out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
      outstanding <= pending_preds.size();
    end
  end

endmodule

// ===== test/taylor_angle_predictor_tb.sv =====
`timescale 1ns / 100ps
// Testbench top of the Taylor angle predictor: clock, reset, request stimulus,
// register phases and verdict. Depends on tap_pkg, taylor_angle_predictor and taylor_angle_predictor_chk.
module taylor_angle_predictor_tb;
  import tap_pkg::*;

  localparam longint ANG_MAX    = 843314857;
  localparam int     STALL_LIMIT = 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  int  fail_count, outstanding;
  bit  no_gaps = 0;   // long stretch with neither side idling
  int  quiet_cycles = 0;

  // sample stream state
  longint      trk_ang, trk_vel;
  logic [31:0] trk_ts;

  always #4 clk = ~clk;

  taylor_angle_predictor u_top (.*);

  taylor_angle_predictor_chk u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata,
    .fail_count, .outstanding
  );

  // result side back-pressure
  always @(posedge clk)
    out_tready <= no_gaps || ($urandom_range(99) >= 28);

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL taylor_angle_predictor");
      $finish;
    end
  end

  // one request; tvalid stays high into the next request unless it idles
  task automatic send_req(bit act, longint ang, logic [31:0] ts, logic [19:0] h);
    if (!no_gaps && $urandom_range(99) < 28) begin
      in_tvalid <= 0;
      do @(posedge clk); while (!no_gaps && $urandom_range(99) < 28);
    end
    in_tvalid <= 1;
    in_tuser  <= act;
    in_tdata  <= {5'd0, h, ts, 31'(ang)};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(logic [2:0] ord, logic [15:0] conf, logic [15:0] miv,
                          logic [29:0] jl);
    write_reg(CFG_ORDER, 32'(ord));
    write_reg(CFG_CONFIDENCE, 32'(conf));
    write_reg(CFG_MIN_IV, 32'(miv));
    write_reg(CFG_JUMP_LIMIT, 32'(jl));
    cfg_valid <= 0;
  endtask

  function automatic longint wrap_ang(longint a);
    if (a > ANG_MAX) a -= 2 * ANG_MAX + 1;
    if (a < -ANG_MAX) a += 2 * ANG_MAX + 1;
    return a;
  endfunction

  function automatic longint rnd_ang();
    return longint'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX;
  endfunction

  function automatic logic [19:0] rnd_horizon();
    return ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 60000));
  endfunction

  // mostly smooth tracks with random content; some queries, early samples, noise, jumps
  task automatic random_phase(int n, int step_max, int min_iv);
    trk_vel = longint'($urandom_range(0, 40000000)) - 20000000;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(19))
        0, 1: send_req(1, rnd_ang(), $urandom, rnd_horizon());
        2, 3: begin
          trk_ts += $urandom_range(0, min_iv);
          send_req(0, wrap_ang(trk_ang + $urandom_range(0, 2000) - 1000), trk_ts, rnd_horizon());
        end
        4, 5: begin
          if ($urandom_range(1)) trk_ts = $urandom;
          else trk_ang = rnd_ang();
          send_req(0, trk_ang, trk_ts, rnd_horizon());
        end
        default: begin
          trk_ts += $urandom_range(min_iv, min_iv + step_max);
          trk_ang = wrap_ang(trk_ang + trk_vel + $urandom_range(0, 400000) - 200000);
          send_req(0, trk_ang, trk_ts, rnd_horizon());
        end
      endcase
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed, reset registers: first sample, query, too soon, jump, wrap
    send_req(1, 0, 0, 0);                       // query with nothing known
    send_req(0, 0, 32'd1000, 0);                 // first sample
    send_req(1, ANG_MAX, 32'hffffffff, 20'hfffff);
    send_req(0, 1000, 32'd1050, 100);            // too soon
    send_req(0, 600000000, 32'd3000, 1000);      // jump
    send_req(0, 600100000, 32'd5000, 5000);
    send_req(0, 600300000, 32'd7000, 20'hfffff);
    send_req(0, ANG_MAX, 32'd9000, 10000);
    send_req(0, -ANG_MAX, 32'd11000, 10000);     // crosses the +-pi seam
    send_req(0, -ANG_MAX + 50000, 32'hfffffff0, 0);
    send_req(0, -ANG_MAX + 90000, 32'd2000, 20'hfffff); // timestamp wraps round
    send_req(0, -ANG_MAX, 32'd100, 30000);        // moves back in time
    send_req(1, 0, 0, 20'hfffff);
    drain();

    // extremes: order 0, zero confidence, zero interval, zero jump limit
    set_regs(3'd0, 16'd0, 16'd0, 30'd0);
    send_req(0, 5000, 32'd20000, 1000);
    send_req(0, 5000, 32'd20000, 1000);           // zero time difference
    send_req(0, 5001, 32'd20010, 1000);
    drain();
    set_regs(3'd7, 16'hffff, 16'd0, 30'd843314857);
    send_req(0, 0, 32'd30000, 1000);
    send_req(0, 1000000, 32'd30000, 1000);        // zero time difference, nonzero change
    send_req(0, ANG_MAX, 32'd30001, 20'hfffff);
    send_req(0, -ANG_MAX, 32'd30002, 20'hfffff);
    send_req(0, 0, 32'd29000, 20'hfffff);
    send_req(1, 0, 0, 20'hfffff);
    drain();

    trk_ang = 0;
    trk_ts  = 32'd100000;
    set_regs(3'd3, 16'd52429, 16'd100, 30'd168662974);
    random_phase(80, 20000, 100);
    set_regs(3'd2, 16'd40000, 16'd500, 30'd843314857);
    random_phase(80, 10000, 500);
    set_regs(3'd1, 16'd1000, 16'd0, 30'd1000000);
    random_phase(60, 5000, 0);
    no_gaps = 1;
    set_regs(3'd4, 16'hffff, 16'd2000, 30'd300000000);
    random_phase(80, 30000, 2000);
    no_gaps = 0;
    set_regs(3'd4, 16'd30000, 16'hffff, 30'd50000000);
    random_phase(70, 100000, 65535);
    set_regs(3'd6, 16'd0, 16'd50, 30'd843314857);
    random_phase(70, 3000, 50);
    set_regs(3'd3, 16'd60000, 16'd0, 30'd0);
    random_phase(60, 20000, 0);
    set_regs(3'd2, 16'd52429, 16'd300, 30'd168662974);
    random_phase(80, 20000, 300);

    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("PASS taylor_angle_predictor");
    else $display("FAIL taylor_angle_predictor");
    $finish;
  end

endmodule
